### rtl/hts_pkg.sv
// ---------------------------------------------------------------------------
// hts_pkg - shared types and constants
// Payload structs, scaling constants and scaling functions for the
// temperature / humidity scale and boxcar average unit.
// ---------------------------------------------------------------------------
package hts_pkg;

	localparam int unsigned AVG_DEPTH_DEF = 8;

	localparam int unsigned RAW_W   = 14;
	localparam int unsigned TEMP_W  = 12;
	localparam int unsigned HUMID_W = 10;
	localparam int unsigned TSUM_W  = 16;
	localparam int unsigned HSUM_W  = 14;

	localparam int unsigned TEMP_SPAN   = 1650;
	localparam int unsigned HUMID_SPAN  = 1000;
	localparam int unsigned TEMP_OFFSET = 400;
	localparam int unsigned FRAC_BITS   = 14;
	localparam int unsigned ROUND_UP    = (1 << FRAC_BITS) - 1;

	// reciprocal divide: exact floor(n/D) for n < 2**15 and D <= 16
	localparam int unsigned MAG_W        = 15;
	localparam int unsigned RECIP_SHIFT  = 19;
	localparam int unsigned RECIP_W      = 20;
	localparam int unsigned PROD_W       = MAG_W + RECIP_W;

	// products: 14 x 11 bits plus rounding fits in 25 bits
	localparam int unsigned TPROD_W = 25;
	localparam int unsigned HPROD_W = 24;

	typedef struct packed {
		logic [RAW_W-1:0] raw_temperature;
		logic [RAW_W-1:0] raw_humidity;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0]  temperature;
		logic        [HUMID_W-1:0] humidity;
		logic signed [TEMP_W-1:0]  avg_temperature;
		logic        [HUMID_W-1:0] avg_humidity;
	} result_t;

	// ceil(raw * 1650 / 16384) - 400
	function automatic logic signed [TEMP_W-1:0] scale_temp(input logic [RAW_W-1:0] raw);
		logic [TPROD_W-1:0] p;
		logic [TEMP_W-1:0]  u;
		p = TPROD_W'(raw) * TPROD_W'(TEMP_SPAN) + TPROD_W'(ROUND_UP);
		u = TEMP_W'(p[TPROD_W-1:FRAC_BITS]) - TEMP_W'(TEMP_OFFSET);
		return $signed(u);
	endfunction

	// ceil(raw * 1000 / 16384)
	function automatic logic [HUMID_W-1:0] scale_humid(input logic [RAW_W-1:0] raw);
		logic [HPROD_W-1:0] p;
		p = HPROD_W'(raw) * HPROD_W'(HUMID_SPAN) + HPROD_W'(ROUND_UP);
		return p[FRAC_BITS +: HUMID_W];
	endfunction

endpackage

### rtl/hts_cell.sv
// ---------------------------------------------------------------------------
// hts_cell - one history slot
// Holds one scaled temperature / humidity pair and hands it to the next
// slot along the chain on every shift.
// ---------------------------------------------------------------------------
module hts_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift,
	input  logic signed [hts_pkg::TEMP_W-1:0]   temp_in,
	input  logic        [hts_pkg::HUMID_W-1:0]  humid_in,
	output logic signed [hts_pkg::TEMP_W-1:0]   temp_out,
	output logic        [hts_pkg::HUMID_W-1:0]  humid_out
);
	import hts_pkg::*;

	logic signed [TEMP_W-1:0]  temp_q;
	logic        [HUMID_W-1:0] humid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q  <= '0;
			humid_q <= '0;
		end else if (shift) begin
			temp_q  <= temp_in;
			humid_q <= humid_in;
		end
	end

	assign temp_out  = temp_q;
	assign humid_out = humid_q;

endmodule

### rtl/humidity_temp_scale_and_average_unit.sv
// ---------------------------------------------------------------------------
// humidity_temp_scale_and_average_unit - sensor scaling with boxcar average
// Path: scaling, running sums, multiply, then the output register.
// Throughput: one sample per cycle while result_stall is low; the running sums
// are updated in a single stage and the history is a shift chain, so nothing recirculates.
// Reset: history slots, running sums and all valid flags cleared; early
// averages therefore include zero entries.
// ---------------------------------------------------------------------------
module humidity_temp_scale_and_average_unit #(
	parameter int unsigned AVG_DEPTH = hts_pkg::AVG_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  hts_pkg::sample_t  sample,
	output logic              result_valid,
	input  logic              result_stall,
	output hts_pkg::result_t  result
);
	import hts_pkg::*;

	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((1 << RECIP_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH);

	// stage advance enables, bubbles collapse
	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_q;

	assign en4 = !v_q  || !result_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign sample_stall = !en1;

	// stage 1: scaling
	logic signed [TEMP_W-1:0]  temp_s1;
	logic        [HUMID_W-1:0] humid_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			temp_s1  <= scale_temp(sample.raw_temperature);
			humid_s1 <= scale_humid(sample.raw_humidity);
		end
	end

	// history chain: slot 0 takes the new pair, the last slot holds the oldest
	logic                      shift;
	logic signed [TEMP_W-1:0]  chain_temp  [0:AVG_DEPTH];
	logic        [HUMID_W-1:0] chain_humid [0:AVG_DEPTH];

	assign shift          = en2 && v_s1;
	assign chain_temp[0]  = temp_s1;
	assign chain_humid[0] = humid_s1;

	for (genvar i = 0; i < AVG_DEPTH; i++) begin : g_cell
		hts_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (shift),
			.temp_in   (chain_temp[i]),
			.humid_in  (chain_humid[i]),
			.temp_out  (chain_temp[i+1]),
			.humid_out (chain_humid[i+1])
		);
	end

	// stage 2: running sums
	logic signed [TSUM_W-1:0]  temp_sum_q,  temp_sum_next;
	logic        [HSUM_W-1:0]  humid_sum_q, humid_sum_next;
	logic signed [TEMP_W-1:0]  temp_s2;
	logic        [HUMID_W-1:0] humid_s2;
	logic signed [TSUM_W-1:0]  temp_sum_s2;
	logic        [HSUM_W-1:0]  humid_sum_s2;

	assign temp_sum_next = temp_sum_q - TSUM_W'(chain_temp[AVG_DEPTH])
		+ TSUM_W'(temp_s1);
	assign humid_sum_next = humid_sum_q - HSUM_W'(chain_humid[AVG_DEPTH])
		+ HSUM_W'(humid_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_sum_q  <= '0;
			humid_sum_q <= '0;
		end else if (shift) begin
			temp_sum_q  <= temp_sum_next;
			humid_sum_q <= humid_sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			temp_s2      <= temp_s1;
			humid_s2     <= humid_s1;
			temp_sum_s2  <= temp_sum_next;
			humid_sum_s2 <= humid_sum_next;
		end
	end

	// stage 3: magnitude times reciprocal
	logic [MAG_W-1:0]          temp_mag;
	logic signed [TEMP_W-1:0]  temp_s3;
	logic        [HUMID_W-1:0] humid_s3;
	logic                      temp_neg_s3;
	logic [PROD_W-1:0]         temp_prod_s3;
	logic [PROD_W-1:0]         humid_prod_s3;

	assign temp_mag = temp_sum_s2[TSUM_W-1] ? MAG_W'(-temp_sum_s2) : temp_sum_s2[MAG_W-1:0];

	always_ff @(posedge clk) begin
		if (en3) begin
			temp_s3       <= temp_s2;
			humid_s3      <= humid_s2;
			temp_neg_s3   <= temp_sum_s2[TSUM_W-1];
			temp_prod_s3  <= PROD_W'(temp_mag) * PROD_W'(RECIP);
			humid_prod_s3 <= PROD_W'(humid_sum_s2) * PROD_W'(RECIP);
		end
	end

	// stage 4: output register, sign restored (truncation toward zero)
	logic [TEMP_W-1:0] temp_quot;

	assign temp_quot = temp_prod_s3[RECIP_SHIFT +: TEMP_W];

	always_ff @(posedge clk) begin
		if (en4) begin
			result.temperature     <= temp_s3;
			result.humidity        <= humid_s3;
			result.avg_temperature <= $signed(temp_neg_s3 ? -temp_quot : temp_quot);
			result.avg_humidity    <= humid_prod_s3[RECIP_SHIFT +: HUMID_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (en1) v_s1 <= sample_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_q  <= v_s3;
		end
	end

	assign result_valid = v_q;

	// stall on the input only when the first stage is holding a sample
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> v_s1)
		else $error("input stalled with empty first stage");

	a_tsum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(temp_sum_q >= -$signed(TSUM_W'(TEMP_OFFSET * AVG_DEPTH))) &&
		(temp_sum_q <= $signed(TSUM_W'((TEMP_SPAN - TEMP_OFFSET) * AVG_DEPTH))))
		else $error("temperature running sum out of range");

	a_hsum_range: assert property (@(posedge clk) disable iff (!arst_n)
		humid_sum_q <= HSUM_W'(HUMID_SPAN * AVG_DEPTH))
		else $error("humidity running sum out of range");

	a_avg_humid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.avg_humidity <= HUMID_W'(HUMID_SPAN)))
		else $error("humidity average out of range");

endmodule
